// File: rtl/core/gbpc_pkg.sv
// ----------------------------------------------------------------------------
// gbpc_pkg
// Shared types, field codes and arithmetic widths of the Gaussian Bayes
// pixel classifier.
// ----------------------------------------------------------------------------
package gbpc_pkg;

	// Item kinds carried on the slave tuser bit
	localparam logic MODE_LOAD     = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	// Parameter slots within one class
	localparam logic [2:0] P_MEAN_R = 3'd0;
	localparam logic [2:0] P_MEAN_G = 3'd1;
	localparam logic [2:0] P_MEAN_B = 3'd2;
	localparam logic [2:0] P_INV_R  = 3'd3;
	localparam logic [2:0] P_INV_G  = 3'd4;
	localparam logic [2:0] P_INV_B  = 3'd5;
	localparam logic [2:0] P_BIAS   = 3'd6;

	// Channel order inside per-channel vectors
	localparam int CH_R = 0;
	localparam int CH_G = 1;
	localparam int CH_B = 2;

	// Datapath widths
	localparam int PIX_W   = 8;   // channel sample
	localparam int MAG_W   = 16;  // |x*256 - mean|, Q8.8
	localparam int PROD_W  = 32;  // |d| * inv_dev, Q.20
	localparam int RND_W   = 28;  // rounded |z|, Q12.16
	localparam int SQ_W    = 56;  // z^2, Q.32
	localparam int SUM_W   = 58;  // sum of three squares
	localparam int HALF_W  = 41;  // 0.5 * sum, Q25.16
	localparam int SCORE_W = 43;  // exact score, signed Q27.16

	localparam logic signed [SCORE_W-1:0] SAT_MAX = 43'sd2147483647;
	localparam logic signed [SCORE_W-1:0] SAT_MIN = -43'sd2147483648;

	// Parameters of one class
	typedef struct packed {
		logic        [2:0][15:0] mean;     // Q8.8 per channel
		logic        [2:0][15:0] inv_dev;  // Q4.12 per channel
		logic signed [31:0]      bias;     // Q16.16
	} class_param_t;

	// One classification result
	typedef struct packed {
		logic        [1:0]  label;
		logic signed [31:0] score;
	} result_t;

endpackage

// File: rtl/core/gbpc_param_store.sv
// ----------------------------------------------------------------------------
// gbpc_param_store
// Class parameter table. One word is written per load transfer; every
// class row is presented to its scoring lane.
// ----------------------------------------------------------------------------
module gbpc_param_store import gbpc_pkg::*; #(
	parameter int NUM_CLASSES = 3
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [1:0]                        class_index,
	input  logic [2:0]                        param_index,
	input  logic [31:0]                       param_value,
	output class_param_t [NUM_CLASSES-1:0]    prm
);

	class_param_t table_q [NUM_CLASSES];

	// Row write, one field per load; unknown slots are dropped
	for (genvar r = 0; r < NUM_CLASSES; r++) begin : g_row
		always_ff @(posedge clk) begin
			if (wr_en && (int'(class_index) == r)) begin
				case (param_index)
					P_MEAN_R: table_q[r].mean[CH_R]    <= param_value[15:0];
					P_MEAN_G: table_q[r].mean[CH_G]    <= param_value[15:0];
					P_MEAN_B: table_q[r].mean[CH_B]    <= param_value[15:0];
					P_INV_R:  table_q[r].inv_dev[CH_R] <= param_value[15:0];
					P_INV_G:  table_q[r].inv_dev[CH_G] <= param_value[15:0];
					P_INV_B:  table_q[r].inv_dev[CH_B] <= param_value[15:0];
					P_BIAS:   table_q[r].bias          <= param_value;
					default: ;
				endcase
			end
		end

		assign prm[r] = table_q[r];
	end

endmodule

// File: rtl/core/gbpc_score_lane.sv
// ----------------------------------------------------------------------------
// gbpc_score_lane
// Five-stage score pipeline for one class:
// bias - 0.5 * sum(((x - mean) * inv_dev)^2), exact, signed Q27.16.
// ----------------------------------------------------------------------------
module gbpc_score_lane import gbpc_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic [2:0][PIX_W-1:0]     px,
	input  class_param_t              prm,
	output logic [SCORE_W-1:0]        score
);

	logic [2:0][MAG_W-1:0]  mag_s1;
	logic [2:0][15:0]       inv_s1;
	logic [2:0][PROD_W-1:0] prod_s2;
	logic [2:0][SQ_W-1:0]   sq_s3;
	logic [SUM_W-1:0]       sum_s4;
	logic signed [31:0]     bias_s1, bias_s2, bias_s3, bias_s4;
	logic signed [SCORE_W-1:0] score_s5;

	logic [2:0][MAG_W-1:0]  mag_c;
	logic [2:0][RND_W-1:0]  rnd_c;
	logic [2:0][SQ_W-1:0]   sq_c;
	logic [HALF_W-1:0]      half_c;

	// Per-channel distance, rounding and square
	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		logic signed [MAG_W:0] diff;
		logic signed [MAG_W:0] diff_neg;

		assign diff     = $signed({1'b0, px[ch], 8'b0}) - $signed({1'b0, prm.mean[ch]});
		assign diff_neg = -diff;
		assign mag_c[ch] = diff[MAG_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
		assign rnd_c[ch] = RND_W'(({1'b0, prod_s2[ch]} + 33'd8) >> 4);
		assign sq_c[ch]  = rnd_c[ch] * rnd_c[ch];
	end

	// Halved sum with round half up
	assign half_c = HALF_W'((sum_s4 + SUM_W'(65536)) >> 17);

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1   <= mag_c;
			inv_s1   <= prm.inv_dev;
			bias_s1  <= prm.bias;
			for (int ch = 0; ch < 3; ch++) begin
				prod_s2[ch] <= mag_s1[ch] * inv_s1[ch];
			end
			bias_s2  <= bias_s1;
			sq_s3    <= sq_c;
			bias_s3  <= bias_s2;
			sum_s4   <= SUM_W'(sq_s3[CH_R]) + SUM_W'(sq_s3[CH_G]) + SUM_W'(sq_s3[CH_B]);
			bias_s4  <= bias_s3;
			score_s5 <= $signed({{(SCORE_W-32){bias_s4[31]}}, bias_s4})
				- $signed({{(SCORE_W-HALF_W){1'b0}}, half_c});
		end
	end

	assign score = score_s5;

endmodule

// File: rtl/core/gbpc_argmax.sv
// ----------------------------------------------------------------------------
// gbpc_argmax
// Registered compare cascade, one class per stage; a later class wins only
// on a strictly higher score, so ties go to the lower index.
// ----------------------------------------------------------------------------
module gbpc_argmax import gbpc_pkg::*; #(
	parameter int NUM_CLASSES = 3,
	localparam int CW = $clog2(NUM_CLASSES)
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic [NUM_CLASSES-1:0][SCORE_W-1:0]  score,
	output logic [CW-1:0]                        best_idx,
	output logic [SCORE_W-1:0]                   best_score
);

	logic [SCORE_W-1:0]                      best_q  [1:NUM_CLASSES-1];
	logic [CW-1:0]                           idx_q   [1:NUM_CLASSES-1];
	logic [NUM_CLASSES-1:0][SCORE_W-1:0]     carry_q [1:NUM_CLASSES-1];

	for (genvar k = 1; k < NUM_CLASSES; k++) begin : g_stage
		logic [SCORE_W-1:0]                  prev_best;
		logic [CW-1:0]                       prev_idx;
		logic [NUM_CLASSES-1:0][SCORE_W-1:0] prev_sc;

		// Stage input: raw scores for the first stage, else prior stage
		if (k == 1) begin : g_first
			assign prev_best = score[0];
			assign prev_idx  = '0;
			assign prev_sc   = score;
		end else begin : g_next
			assign prev_best = best_q[k-1];
			assign prev_idx  = idx_q[k-1];
			assign prev_sc   = carry_q[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if ($signed(prev_sc[k]) > $signed(prev_best)) begin
					best_q[k] <= prev_sc[k];
					idx_q[k]  <= CW'(k);
				end else begin
					best_q[k] <= prev_best;
					idx_q[k]  <= prev_idx;
				end
				carry_q[k] <= prev_sc;
			end
		end
	end

	assign best_idx   = idx_q[NUM_CLASSES-1];
	assign best_score = best_q[NUM_CLASSES-1];

endmodule

// File: rtl/core/gaussian_bayes_pixel_classifier.sv
// Path from the input transfer to m_tvalid: five score stages, the first loaded
// at the transfer edge, NUM_CLASSES - 1 compare stages, one output register.
// Throughput: one item per cycle while the skid register is empty, one score
// lane per class, pipelined compares.
// Load items give no result. Reset clears the valid chain and the output/skid valids;
// the parameter table is not cleared and must be loaded before classifying.
// ----------------------------------------------------------------------------
// gaussian_bayes_pixel_classifier
// Per-pixel Gaussian naive Bayes classifier over a loadable class table,
// log-domain scoring, best class out with its saturated score.
// ----------------------------------------------------------------------------
module gaussian_bayes_pixel_classifier import gbpc_pkg::*; #(
	parameter int NUM_CLASSES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// class_index[1:0], param_index[4:2], param_value[36:5],
	// red[44:37], green[52:45], blue[60:53], zero [63:61]
	input  logic [63:0] s_tdata,
	// mode[0]
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// class_label[1:0], winning_score[33:2], zero [39:34]
	output logic [39:0] m_tdata
);

	localparam int CW  = $clog2(NUM_CLASSES);
	localparam int LAT = 5 + NUM_CLASSES - 1;

	logic                                accept, adv, wr_en, cls_in, push;
	logic                                mode;
	logic [1:0]                          class_index;
	logic [2:0]                          param_index;
	logic [31:0]                         param_value;
	logic [2:0][PIX_W-1:0]               px;
	class_param_t [NUM_CLASSES-1:0]      prm;
	logic [NUM_CLASSES-1:0][SCORE_W-1:0] score;
	logic [CW-1:0]                       best_idx;
	logic [SCORE_W-1:0]                  best_score;
	logic [LAT-1:0]                      v_q;
	result_t                             res_c, out_q, skid_q;
	logic                                out_valid_q, skid_valid_q;

	// Field unpack
	assign mode        = s_tuser[0];
	assign class_index = s_tdata[1:0];
	assign param_index = s_tdata[4:2];
	assign param_value = s_tdata[36:5];
	assign px[CH_R]    = s_tdata[44:37];
	assign px[CH_G]    = s_tdata[52:45];
	assign px[CH_B]    = s_tdata[60:53];

	// Pipeline advances unless the skid register is holding a result
	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;
	assign wr_en    = accept && (mode == MODE_LOAD) && (int'(class_index) < NUM_CLASSES);
	assign cls_in   = accept && (mode == MODE_CLASSIFY);

	gbpc_param_store #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_store (
		.clk         (clk),
		.wr_en       (wr_en),
		.class_index (class_index),
		.param_index (param_index),
		.param_value (param_value),
		.prm         (prm)
	);

	for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
		gbpc_score_lane u_lane (
			.clk   (clk),
			.en    (adv),
			.px    (px),
			.prm   (prm[c]),
			.score (score[c])
		);
	end

	gbpc_argmax #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_argmax (
		.clk        (clk),
		.en         (adv),
		.score      (score),
		.best_idx   (best_idx),
		.best_score (best_score)
	);

	// Valid chain alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-2:0], cls_in};
		end
	end

	// Saturate winner to 32 bits
	always_comb begin
		res_c.label = 2'(best_idx);
		if ($signed(best_score) > SAT_MAX) begin
			res_c.score = 32'sh7FFFFFFF;
		end else if ($signed(best_score) < SAT_MIN) begin
			res_c.score = 32'sh80000000;
		end else begin
			res_c.score = best_score[31:0];
		end
	end

	assign push = adv && v_q[LAT-1];

	// Output register with skid stage: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register with skid stage: data
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : res_c;
		end else if (push) begin
			skid_q <= res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.score, out_q.label};

	// Skid only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a result while output is empty");

	// Pipeline frozen while the skid register is full
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_q))
		else $error("pipeline moved during stall");

	// A result pushed into a stalled output lands in the skid register
	a_push_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && push) |=> skid_valid_q)
		else $error("result lost at stalled output");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Gaussian Bayes pixel classifier: fills the class
// table, runs a directed table of loads and pixels, then random load and
// pixel sequences under bursty input and stalling output, and checks every
// result transfer against a log-domain scoring model of its own.
// ----------------------------------------------------------------------------
module tb;
	import gbpc_pkg::*;

	localparam int NUM_CLASSES  = 3;
	localparam int PARAM_SLOTS  = 7;
	localparam int TOTAL_ITEMS  = 1150;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 100;
	localparam int DRAIN_CYCLES = NUM_CLASSES + 9;

	// Codes that the block must ignore on a load
	localparam logic [1:0] CLASS_OUT_OF_RANGE = 2'd3;
	localparam logic [2:0] P_OUT_OF_RANGE     = 3'd7;

	typedef struct {
		logic        mode;
		logic [1:0]  class_index;
		logic [2:0]  param_index;
		logic [31:0] param_value;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		bit          has_typed;
		result_t     typed;
	} stream_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // class_index, param_index, param_value, red, green, blue
	logic [0:0]  s_tuser;   // mode
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // class_label, winning_score

	// Mirror of the class table and the decisions still in flight
	logic [31:0] class_params [NUM_CLASSES][PARAM_SLOTS];
	result_t     expected_decisions [$];
	result_t     oldest_decision;

	int error_count   = 0;
	int results_seen  = 0;
	int cycle_count   = 0;
	int burst_left    = 0;
	bit hold_request  = 1'b0;

	gaussian_bayes_pixel_classifier #(.NUM_CLASSES(NUM_CLASSES)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic flag_error(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Exact log-domain score of one class for one pixel
	function automatic longint class_score(input int c, input logic [7:0] r, g, b);
		logic [7:0]       px [3];
		longint           x_q, mean_q, d, bias;
		longint unsigned  mag, p, m, s, h;
		px[0] = r;
		px[1] = g;
		px[2] = b;
		s = 0;
		for (int ch = 0; ch < 3; ch++) begin
			x_q    = longint'({px[ch], 8'd0});
			mean_q = longint'(class_params[c][P_MEAN_R + ch][15:0]);
			d      = x_q - mean_q;
			mag    = (d < 0) ? -d : d;
			p      = mag * class_params[c][P_INV_R + ch][15:0];
			m      = (p + 8) >> 4;
			s      = s + m * m;
		end
		h    = (s + 64'd65536) >> 17;
		bias = longint'($signed(class_params[c][P_BIAS]));
		return bias - longint'(h);
	endfunction

	// Apply one accepted item to the mirror; a pixel queues its decision
	task automatic absorb_item(input stream_item_t it);
		result_t dec;
		longint  best, sc;
		int      win;
		if (it.mode == MODE_LOAD) begin
			if (it.class_index < NUM_CLASSES && it.param_index <= P_BIAS)
				class_params[it.class_index][it.param_index] = it.param_value;
		end else begin
			best = class_score(0, it.red, it.green, it.blue);
			win  = 0;
			for (int c = 1; c < NUM_CLASSES; c++) begin
				sc = class_score(c, it.red, it.green, it.blue);
				if (sc > best) begin
					best = sc;
					win  = c;
				end
			end
			if (best > 64'sd2147483647)
				best = 64'sd2147483647;
			if (best < -64'sd2147483648)
				best = -64'sd2147483648;
			dec.label = win[1:0];
			dec.score = best[31:0];
			if (it.has_typed)
				dec = it.typed;
			expected_decisions = {expected_decisions, dec};
		end
	endtask

	// Offer one item until transferred, then keep the burst pacing
	task automatic transfer_item(input stream_item_t it);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= it.mode;
		s_tdata  <= {3'd0, it.blue, it.green, it.red, it.param_value,
			it.param_index, it.class_index};
		do @(posedge clk); while (!s_tready);
		absorb_item(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 24);
		end
	endtask

	// Idle the input until no decision is left in flight
	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_decisions.size() != 0);
	endtask

	// Load item; pixel fields carry junk
	function automatic stream_item_t load_item(input logic [1:0] c, input logic [2:0] p,
		input logic [31:0] v);
		stream_item_t it;
		it.mode        = MODE_LOAD;
		it.class_index = c;
		it.param_index = p;
		it.param_value = v;
		it.red         = 8'($urandom);
		it.green       = 8'($urandom);
		it.blue        = 8'($urandom);
		it.has_typed   = 1'b0;
		it.typed       = '0;
		return it;
	endfunction

	// Pixel item; load fields carry junk
	function automatic stream_item_t pixel_item(input logic [7:0] r, g, b);
		stream_item_t it;
		it.mode        = MODE_CLASSIFY;
		it.class_index = 2'($urandom);
		it.param_index = 3'($urandom);
		it.param_value = $urandom;
		it.red         = r;
		it.green       = g;
		it.blue        = b;
		it.has_typed   = 1'b0;
		it.typed       = '0;
		return it;
	endfunction

	function automatic stream_item_t with_result(input stream_item_t it,
		input logic [1:0] label, input logic [31:0] score);
		it.has_typed   = 1'b1;
		it.typed.label = label;
		it.typed.score = score;
		return it;
	endfunction

	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Parameter values: mostly in a range that keeps scores close, some extremes
	function automatic logic [31:0] random_param(input logic [2:0] p);
		logic [15:0] upper;
		upper = 16'($urandom);
		if ($urandom_range(0, 4) == 0) begin
			if (p == P_BIAS) begin
				case ($urandom_range(0, 2))
					0:       return 32'h7FFF_FFFF;
					1:       return 32'h8000_0000;
					default: return 32'h0000_0000;
				endcase
			end
			return {upper, ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF};
		end
		if (p == P_BIAS)
			return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
		if (p >= P_INV_R && $urandom_range(0, 3) != 0)
			return {upper, 16'($urandom_range(0, 16'h0400))};
		return {upper, 16'($urandom)};
	endfunction

	// Result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (expected_decisions.size() == 0) begin
				flag_error($sformatf("result %0d arrived with none expected", results_seen));
			end else begin
				oldest_decision = expected_decisions.pop_front();
				if (m_tdata[1:0] !== oldest_decision.label)
					flag_error($sformatf("result %0d class_label %0d, expected %0d",
						results_seen, m_tdata[1:0], oldest_decision.label));
				if (m_tdata[33:2] !== oldest_decision.score)
					flag_error($sformatf("result %0d winning_score %0d, expected %0d",
						results_seen, $signed(m_tdata[33:2]),
						$signed(oldest_decision.score)));
			end
		end
	end

	// Output side: stall styles change per phase; a hold request forces a long stall
	initial begin
		int hold_left;
		int phase_left;
		int phase_cnt;
		int style;
		hold_left  = 0;
		phase_left = 0;
		phase_cnt  = 0;
		style      = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (phase_left == 0) begin
					style      = $urandom_range(0, 3);
					phase_left = $urandom_range(20, 200);
					phase_cnt  = 0;
				end
				phase_left--;
				phase_cnt++;
				case (style)
					0:       m_tready <= 1'b1;
					1:       m_tready <= 1'($urandom_range(0, 1));
					2:       m_tready <= (phase_cnt % 4 != 3);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Stimulus
	initial begin
		stream_item_t directed [$];
		int           counted;
		int           target;
		int           kind;
		int           n;
		int           src;
		int           dst;
		bit           mid_pause_done;
		logic [2:0]   p;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;

		// Fill the whole table first: inverse deviations zero so scores equal the bias
		for (int c = 0; c < NUM_CLASSES; c++) begin
			for (int ch = 0; ch < 3; ch++) begin
				directed = {directed, load_item(2'(c), 3'(P_MEAN_R + ch),
					(c == 0) ? 32'h0000_0000 : (c == 1) ? 32'h0000_FFFF : 32'hFFFF_8000)};
				directed = {directed, load_item(2'(c), 3'(P_INV_R + ch),
					(c == 2) ? 32'hFFFF_0000 : 32'h0000_0000)};
			end
			directed = {directed, load_item(2'(c), P_BIAS, 32'h0000_0000)};
		end
		// All classes tie: lowest index wins
		directed = {directed,
			with_result(pixel_item(8'd255, 8'd255, 8'd255), 2'd0, 32'h0)};
		// Top bias on class 2; loads outside the table must not land anywhere
		directed = {directed, load_item(2'd2, P_BIAS, 32'h7FFF_FFFF)};
		directed = {directed, load_item(CLASS_OUT_OF_RANGE, P_BIAS, 32'h7FFF_FFFF)};
		directed = {directed, load_item(2'd0, P_OUT_OF_RANGE, 32'h7FFF_FFFF)};
		directed = {directed,
			with_result(pixel_item(8'd0, 8'd255, 8'd0), 2'd2, 32'h7FFF_FFFF)};
		// Bottom bias everywhere: tie at the negative extreme
		for (int c = 0; c < NUM_CLASSES; c++)
			directed = {directed, load_item(2'(c), P_BIAS, 32'h8000_0000)};
		directed = {directed,
			with_result(pixel_item(8'd255, 8'd0, 8'd255), 2'd0, 32'h8000_0000)};
		// Largest inverse deviation: score below the saturation floor
		directed = {directed, load_item(2'd1, P_INV_R, 32'hFFFF_FFFF)};
		directed = {directed, pixel_item(8'd255, 8'd0, 8'd0)};
		directed = {directed, load_item(2'd1, P_BIAS, 32'h0000_0000)};
		directed = {directed, pixel_item(8'd0, 8'd128, 8'd255)};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			transfer_item(directed[i]);
		pause_until_drained();

		// Random sequences; the output holds off at the start of this phase
		hold_request   = 1'b1;
		counted        = 0;
		target         = TOTAL_ITEMS - directed.size();
		mid_pause_done = 1'b0;
		while (counted < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				// run of pixels
				n = $urandom_range(1, 16);
				repeat (n)
					transfer_item(pixel_item(random_channel(), random_channel(),
						random_channel()));
				counted += n;
			end else if (kind < 85) begin
				// a few parameter updates
				n = $urandom_range(1, 4);
				repeat (n) begin
					p = 3'($urandom_range(P_MEAN_R, P_BIAS));
					transfer_item(load_item(2'($urandom_range(0, NUM_CLASSES - 1)), p,
						random_param(p)));
				end
				counted += n;
			end else if (kind < 93) begin
				// copy one class onto another so ties come up
				src = $urandom_range(0, NUM_CLASSES - 1);
				dst = (src + $urandom_range(1, NUM_CLASSES - 1)) % NUM_CLASSES;
				for (int q = 0; q < PARAM_SLOTS; q++)
					transfer_item(load_item(2'(dst), 3'(q), class_params[src][q]));
				transfer_item(pixel_item(random_channel(), random_channel(),
					random_channel()));
				counted += PARAM_SLOTS + 1;
			end else begin
				// loads the block has to drop
				if ($urandom_range(0, 1) == 0)
					transfer_item(load_item(CLASS_OUT_OF_RANGE, 3'($urandom), $urandom));
				else
					transfer_item(load_item(2'($urandom), P_OUT_OF_RANGE, $urandom));
				counted += 1;
			end
			if (!mid_pause_done && counted >= target / 2) begin
				pause_until_drained();
				mid_pause_done = 1'b1;
			end
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_decisions.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
